/* design/fit_policy_block_allocator_assert.svh */
// ----------------------------------------------------------------------------
// fit policy block allocator: assertion macros
// shared concurrent assertion forms on clk and rst_n
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

// property that must hold at every edge out of reset
`define FPBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge, consequent at the next
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/fpba_pkg.sv */
// ----------------------------------------------------------------------------
// fpba_pkg
// types, codes and sizes shared by the allocator modules
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int ADDR_BITS = 20;
  localparam int NEED_W    = ADDR_BITS + 1;
  localparam int SIDX_W    = 10;
  localparam int SCNT_W    = 11;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int NODE_BYTES_DEF   = 24;
  localparam int HEADER_BYTES_DEF = 24;

  localparam logic [ADDR_BITS-1:0] REGION_RESET = 20'd65536;
  localparam logic [ADDR_BITS:0]   ROUND_MASK   = 21'd7;

  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_WORST = 2'd1;
  localparam logic [1:0] POL_FIRST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOFIT   = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [2:0] {
    CELL_NOP, CELL_RESET, CELL_SET, CELL_WRITE, CELL_UP, CELL_DN
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_ACT1, ST_ACT2, ST_ACT3, ST_DONE
  } state_t;

  typedef struct packed {
    logic                 mode;
    logic [ADDR_BITS-1:0] request_size;
    logic [ADDR_BITS-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] payload_address;
    logic [1:0]           status;
  } res_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] pay;
    logic                 free_bit;
  } seg_t;

  typedef struct packed {
    cell_op_t             op;
    logic [SIDX_W-1:0]    idx;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] pay;
    logic                 free_bit;
  } act_t;

  typedef struct packed {
    act_t                 act;
    logic [SCNT_W-1:0]    count;
    logic                 mode;
    logic [1:0]           policy;
    logic [NEED_W-1:0]    need;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] rover;
  } cmd_t;

  typedef struct packed {
    logic                 hit;
    logic [SIDX_W-1:0]    idx;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] pay;
    logic                 hit2;
    logic [ADDR_BITS-1:0] start2;
    logic [SIDX_W-1:0]    idx2;
    logic [ADDR_BITS-1:0] pay2;
    logic                 last_free;
    logic [ADDR_BITS-1:0] last_pay;
    logic                 prev_free;
    logic [ADDR_BITS-1:0] prev_pay;
    logic                 just;
    logic                 next_free;
    logic [ADDR_BITS-1:0] next_pay;
  } scan_t;

endpackage

/* design/fpba_cell.sv */
// ----------------------------------------------------------------------------
// fpba_cell
// one table entry: holds a segment, shifts with its neighbours, scan stage
// ----------------------------------------------------------------------------
module fpba_cell #(
  parameter int CELL_IDX = 0,
  parameter int OVH      = 48
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fpba_pkg::cmd_t  cmd,
  input  fpba_pkg::seg_t  left_in,
  input  fpba_pkg::seg_t  right_in,
  input  fpba_pkg::scan_t scan_in,
  output fpba_pkg::seg_t  seg_out,
  output fpba_pkg::scan_t scan_out
);
  import fpba_pkg::*;

  localparam logic [SCNT_W-1:0]    MY_IDX = SCNT_W'(CELL_IDX);
  localparam logic [ADDR_BITS-1:0] OVH_A  = ADDR_BITS'(OVH);
  localparam logic [ADDR_BITS-1:0] RST_PAY =
    (REGION_RESET > OVH_A) ? REGION_RESET - OVH_A : '0;

  seg_t  seg_r, seg_nxt;
  scan_t scan_r, scan_nxt;
  logic  valid, fits, take, take2;
  logic [SCNT_W-1:0] cmd_idx;

  assign valid   = MY_IDX < cmd.count;
  assign cmd_idx = SCNT_W'(cmd.act.idx);
  assign fits    = valid && seg_r.free_bit && ({1'b0, seg_r.pay} >= cmd.need);

  // segment update
  always_comb begin
    seg_nxt = seg_r;
    case (cmd.act.op)
      CELL_RESET: begin
        seg_nxt.start    = '0;
        seg_nxt.pay      = (MY_IDX == '0) ? cmd.act.pay : '0;
        seg_nxt.free_bit = (MY_IDX == '0);
      end
      CELL_SET: begin
        if (MY_IDX == cmd_idx) begin
          seg_nxt.pay      = cmd.act.pay;
          seg_nxt.free_bit = cmd.act.free_bit;
        end
      end
      CELL_WRITE: begin
        if (MY_IDX == cmd_idx) begin
          seg_nxt.start    = cmd.act.start;
          seg_nxt.pay      = cmd.act.pay;
          seg_nxt.free_bit = cmd.act.free_bit;
        end
      end
      CELL_UP: if (MY_IDX > cmd_idx) seg_nxt = left_in;
      CELL_DN: if (MY_IDX >= cmd_idx) seg_nxt = right_in;
      default: seg_nxt = seg_r;
    endcase
  end

  // scan stage
  always_comb begin
    take = 1'b0;
    if (cmd.mode == MODE_FREE) begin
      take = valid && !seg_r.free_bit && !scan_in.hit &&
             (seg_r.start + OVH_A == cmd.addr);
    end else begin
      case (cmd.policy)
        POL_BEST:  take = fits && (!scan_in.hit || seg_r.pay < scan_in.pay);
        POL_WORST: take = fits && (!scan_in.hit || seg_r.pay > scan_in.pay);
        POL_FIRST: take = fits && !scan_in.hit;
        default:   take = fits && !scan_in.hit && (seg_r.start >= cmd.rover);
      endcase
    end
    take2 = (cmd.mode == MODE_ALLOC) && (cmd.policy == POL_NEXT) && fits && !scan_in.hit2;

    scan_nxt           = scan_in;
    scan_nxt.last_free = valid && seg_r.free_bit;
    scan_nxt.last_pay  = seg_r.pay;
    scan_nxt.just      = take;
    if (scan_in.just) begin
      scan_nxt.next_free = valid && seg_r.free_bit;
      scan_nxt.next_pay  = seg_r.pay;
    end
    if (take) begin
      scan_nxt.hit       = 1'b1;
      scan_nxt.idx       = SIDX_W'(CELL_IDX);
      scan_nxt.start     = seg_r.start;
      scan_nxt.pay       = seg_r.pay;
      scan_nxt.prev_free = scan_in.last_free;
      scan_nxt.prev_pay  = scan_in.last_pay;
      scan_nxt.next_free = 1'b0;
      scan_nxt.next_pay  = '0;
    end
    if (take2) begin
      scan_nxt.hit2   = 1'b1;
      scan_nxt.idx2   = SIDX_W'(CELL_IDX);
      scan_nxt.start2 = seg_r.start;
      scan_nxt.pay2   = seg_r.pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r.start    <= '0;
      seg_r.pay      <= (CELL_IDX == 0) ? RST_PAY : '0;
      seg_r.free_bit <= (CELL_IDX == 0);
    end else begin
      seg_r <= seg_nxt;
    end
    scan_r <= scan_nxt;
  end

  assign seg_out  = seg_r;
  assign scan_out = scan_r;

endmodule

/* design/fpba_ctrl.sv */
// ----------------------------------------------------------------------------
// fpba_ctrl
// request sequencer: starts the scan, decides, drives table edits, result
// ----------------------------------------------------------------------------
module fpba_ctrl #(
  parameter int MAX_SEGMENTS = fpba_pkg::MAX_SEGMENTS_DEF,
  parameter int OVH          = fpba_pkg::NODE_BYTES_DEF + fpba_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fpba_pkg::req_t                 in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fpba_pkg::res_t                 out_res,
  input  logic                           region_we,
  input  logic [fpba_pkg::ADDR_BITS-1:0] region_val,
  input  logic [1:0]                     policy,
  input  fpba_pkg::scan_t                scan_res,
  output fpba_pkg::cmd_t                 cmd
);
  import fpba_pkg::*;

  localparam logic [SCNT_W-1:0]    MAX_C   = SCNT_W'(MAX_SEGMENTS);
  localparam logic [SCNT_W-1:0]    LAST_C  = SCNT_W'(MAX_SEGMENTS - 1);
  localparam logic [ADDR_BITS-1:0] OVH_A   = ADDR_BITS'(OVH);
  localparam logic [ADDR_BITS+1:0] OVH_L   = (ADDR_BITS+2)'(OVH);

  state_t state_r, state_nxt;
  logic [SCNT_W-1:0]    cnt_r, seg_count_r, count_nxt;
  logic [ADDR_BITS-1:0] rover_r, rover_nxt;
  logic                 mode_r, zero_r;
  logic [NEED_W-1:0]    need_r;
  logic [ADDR_BITS-1:0] addr_r;
  act_t act1_r, act2_r, act3_r, a1, a2, a3;
  res_t res_r, res_nxt, out_r;
  logic out_valid_r;
  logic accept, out_free;

  logic                 ch_hit;
  logic [SIDX_W-1:0]    ch_idx;
  logic [ADDR_BITS-1:0] ch_start, ch_pay;
  logic                 split;
  logic [ADDR_BITS+1:0] need_ovh;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (cnt_r == LAST_C) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_ACT1;
      ST_ACT1:   state_nxt = ST_ACT2;
      ST_ACT2:   state_nxt = ST_ACT3;
      ST_ACT3:   state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    cmd.count  = seg_count_r;
    cmd.mode   = mode_r;
    cmd.policy = policy;
    cmd.need   = need_r;
    cmd.addr   = addr_r;
    cmd.rover  = rover_r;
    cmd.act    = '{op: CELL_NOP, idx: '0, start: '0, pay: '0, free_bit: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        if (region_we) begin
          cmd.act.op  = CELL_RESET;
          cmd.act.pay = (region_val > OVH_A) ? region_val - OVH_A : '0;
        end
      end
      ST_ACT1: cmd.act = act1_r;
      ST_ACT2: cmd.act = act2_r;
      ST_ACT3: cmd.act = act3_r;
      default: ;
    endcase
  end

  // decision on the scan result
  always_comb begin
    a1        = '{op: CELL_NOP, idx: '0, start: '0, pay: '0, free_bit: 1'b0};
    a2        = a1;
    a3        = a1;
    count_nxt = seg_count_r;
    rover_nxt = rover_r;
    res_nxt   = '{payload_address: '0, status: STATUS_OK};
    split     = 1'b0;
    ch_hit    = scan_res.hit;
    ch_idx    = scan_res.idx;
    ch_start  = scan_res.start;
    ch_pay    = scan_res.pay;
    if (policy == POL_NEXT && !scan_res.hit) begin
      ch_hit   = scan_res.hit2;
      ch_idx   = scan_res.idx2;
      ch_start = scan_res.start2;
      ch_pay   = scan_res.pay2;
    end
    need_ovh = {1'b0, need_r} + OVH_L;
    if (mode_r == MODE_ALLOC) begin
      if (zero_r || !ch_hit) begin
        res_nxt.status = STATUS_NOFIT;
      end else begin
        split = ({2'b00, ch_pay} > need_ovh) && (seg_count_r < MAX_C);
        res_nxt.payload_address = ch_start + OVH_A;
        if (policy == POL_NEXT) rover_nxt = ch_start;
        if (split) begin
          a1 = '{op: CELL_UP, idx: ch_idx + 1'b1, start: '0, pay: '0, free_bit: 1'b0};
          a2 = '{op: CELL_WRITE, idx: ch_idx + 1'b1,
                 start: ch_start + OVH_A + need_r[ADDR_BITS-1:0],
                 pay: ch_pay - need_r[ADDR_BITS-1:0] - OVH_A, free_bit: 1'b1};
          a3 = '{op: CELL_SET, idx: ch_idx, start: '0,
                 pay: need_r[ADDR_BITS-1:0], free_bit: 1'b0};
          count_nxt = seg_count_r + 1'b1;
        end else begin
          a1 = '{op: CELL_SET, idx: ch_idx, start: '0, pay: ch_pay, free_bit: 1'b0};
        end
      end
    end else if (addr_r != '0) begin
      if (!scan_res.hit) begin
        res_nxt.status = STATUS_UNKNOWN;
      end else if (scan_res.prev_free && scan_res.next_free) begin
        // both neighbours free: fold all three into the lower one
        a1 = '{op: CELL_SET, idx: scan_res.idx - 1'b1, start: '0,
               pay: scan_res.prev_pay + scan_res.pay + scan_res.next_pay + OVH_A + OVH_A,
               free_bit: 1'b1};
        a2 = '{op: CELL_DN, idx: scan_res.idx, start: '0, pay: '0, free_bit: 1'b0};
        a3 = a2;
        count_nxt = seg_count_r - SCNT_W'(2);
      end else if (scan_res.prev_free) begin
        a1 = '{op: CELL_SET, idx: scan_res.idx - 1'b1, start: '0,
               pay: scan_res.prev_pay + scan_res.pay + OVH_A, free_bit: 1'b1};
        a2 = '{op: CELL_DN, idx: scan_res.idx, start: '0, pay: '0, free_bit: 1'b0};
        count_nxt = seg_count_r - 1'b1;
      end else if (scan_res.next_free) begin
        a1 = '{op: CELL_SET, idx: scan_res.idx, start: '0,
               pay: scan_res.pay + scan_res.next_pay + OVH_A, free_bit: 1'b1};
        a2 = '{op: CELL_DN, idx: scan_res.idx + 1'b1, start: '0, pay: '0, free_bit: 1'b0};
        count_nxt = seg_count_r - 1'b1;
      end else begin
        a1 = '{op: CELL_SET, idx: scan_res.idx, start: '0, pay: scan_res.pay, free_bit: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      seg_count_r <= SCNT_W'(1);
      rover_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_r == ST_SCAN) ? cnt_r + 1'b1 : '0;
      if (state_r == ST_IDLE && region_we) begin
        seg_count_r <= SCNT_W'(1);
        rover_r     <= '0;
      end else if (state_r == ST_DECIDE) begin
        seg_count_r <= count_nxt;
        rover_r     <= rover_nxt;
      end
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                out_valid_r <= 1'b0;
    end
    if (accept) begin
      mode_r <= in_req.mode;
      zero_r <= (in_req.request_size == '0);
      need_r <= ({1'b0, in_req.request_size} + ROUND_MASK) & ~ROUND_MASK;
      addr_r <= in_req.free_address;
    end
    if (state_r == ST_DECIDE) begin
      act1_r <= a1;
      act2_r <= a2;
      act3_r <= a3;
      res_r  <= res_nxt;
    end
    if (state_r == ST_DONE && out_free) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `include "fit_policy_block_allocator_assert.svh"

  `FPBA_ASSERT(a_count_range, (seg_count_r != '0) && (seg_count_r <= MAX_C), "segment count out of range")
  `FPBA_ASSERT_NEXT(a_accept_scan, accept, state_r == ST_SCAN, "accepted request did not start a scan")
  `FPBA_ASSERT_NEXT(a_region_reform, (state_r == ST_IDLE) && region_we, (seg_count_r == SCNT_W'(1)) && (rover_r == '0), "region write did not re-form the table")
  `FPBA_ASSERT_NEXT(a_result_once, (state_r == ST_DONE) && out_free, out_valid_r, "finished request gave no result")

endmodule

/* design/fit_policy_block_allocator.sv */
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// segment table allocator with best, worst, first and next fit policies
// ----------------------------------------------------------------------------
//  channel  | ports                        | moves
//  ---------+------------------------------+-------------------------------
//  in       | in_valid in_stall in_req     | allocate or free request
//  out      | out_valid out_stall out_res  | payload address and status
//  cfg      | psel penable pwrite paddr .. | region_bytes @0, fit_policy @4
//
// a request scans all MAX_SEGMENTS entries; the next waits until it is done:
// the scan record walks the chain one cell per cycle, then up to three table
// edits are broadcast to the row; a result waiting on out_stall holds the
// next request at its end only. rst_n (synchronous) restores a 65536-byte
// region, best fit and one free segment; an idle-time region_bytes write
// re-forms the table as one free segment at once and leaves the policy alone.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
  parameter int MAX_SEGMENTS = fpba_pkg::MAX_SEGMENTS_DEF,
  parameter int NODE_BYTES   = fpba_pkg::NODE_BYTES_DEF,
  parameter int HEADER_BYTES = fpba_pkg::HEADER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  // request channel
  input  logic           in_valid,
  output logic           in_stall,
  input  fpba_pkg::req_t in_req,
  // result channel
  output logic           out_valid,
  input  logic           out_stall,
  output fpba_pkg::res_t out_res,
  // register port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import fpba_pkg::*;

  localparam int OVH = NODE_BYTES + HEADER_BYTES;

  logic [ADDR_BITS-1:0] region_r;
  logic [1:0]           policy_r;
  logic                 wr, region_we;

  cmd_t  cmd;
  seg_t  segs  [MAX_SEGMENTS];
  scan_t scans [MAX_SEGMENTS];

  // register port: always ready, word index in paddr[2]
  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign region_we = wr && !paddr[2];
  assign prdata    = paddr[2] ? {30'd0, policy_r} : {{(32-ADDR_BITS){1'b0}}, region_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= REGION_RESET;
      policy_r <= POL_BEST;
    end else if (wr) begin
      if (paddr[2]) policy_r <= pwdata[1:0];
      else          region_r <= pwdata[ADDR_BITS-1:0];
    end
  end

  // sequencer
  fpba_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .OVH         (OVH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .region_we (region_we),
    .region_val(pwdata[ADDR_BITS-1:0]),
    .policy    (policy_r),
    .scan_res  (scans[MAX_SEGMENTS-1]),
    .cmd       (cmd)
  );

  // row of table cells; the scan record enters at cell 0 empty
  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    seg_t  left_seg, right_seg;
    scan_t scan_in;

    if (g == 0) begin : g_head
      assign left_seg = '0;
      assign scan_in  = '0;
    end else begin : g_body
      assign left_seg = segs[g-1];
      assign scan_in  = scans[g-1];
    end
    if (g == MAX_SEGMENTS - 1) begin : g_tail
      assign right_seg = '0;
    end else begin : g_mid
      assign right_seg = segs[g+1];
    end

    fpba_cell #(
      .CELL_IDX(g),
      .OVH     (OVH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .left_in (left_seg),
      .right_in(right_seg),
      .scan_in (scan_in),
      .seg_out (segs[g]),
      .scan_out(scans[g])
    );
  end

endmodule
